[rtl/wgm_pkg.sv]
// wgm_pkg: shared constants and types for the wildcard glob matcher
// used by wgm_step and wildcard_glob_matcher; no dependencies
package wgm_pkg;

  localparam int MAX_PATTERN = 8;     // pattern bytes held in configuration
  localparam int CHAR_W      = 8;
  localparam int PATTERN_W   = 64;    // eight bytes, first in lowest byte
  localparam int POS_W       = 4;     // holds positions 0..MAX_PATTERN
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD      = 2'd2;

  // matching state carried between iterations
  typedef struct packed {
    logic [POS_W-1:0] pattern_pos;
    logic             star_active;
    logic             resume_valid;
    logic [POS_W-1:0] resume_pos;
    logic             decided_end;
    logic             still_ok;
    logic             after_star;   // star just taken, look-ahead check pending
  } match_state_t;

  localparam match_state_t STATE_CLEAR = '{
    pattern_pos:  '0,
    star_active:  1'b0,
    resume_valid: 1'b0,
    resume_pos:   '0,
    decided_end:  1'b0,
    still_ok:     1'b1,
    after_star:   1'b0
  };

endpackage

[rtl/wildcard_glob_matcher.sv]
// wildcard_glob_matcher: streaming glob matcher, top level
// sequencer around the shared wgm_step iteration unit
// depends on wgm_pkg and wgm_step
//
//  channel   signals                          direction  carries
//  text      text_valid, text_stall, text_char   in      one text byte per request
//  result    result_valid, result_stall, matched out     match bit at terminator
//  cfg       cfg_write, cfg_index, cfg_data      in      register write, no read-back
//
// a request is taken only while the sequencer is idle (text_stall low)
// each byte then steps through the pattern one iteration at a time
//   (a star adds a look-ahead check), using the single compare unit on the pattern position
// a terminator then loads the result register, waiting while it is still full
// synchronous active-high reset clears all but the cur_char and matched registers
// result_stall holds the result register; text is taken until the next terminator
module wildcard_glob_matcher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_stall,
  input  logic [wgm_pkg::CHAR_W-1:0]      text_char,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            matched,
  input  logic                            cfg_write,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wgm_pkg::PATTERN_W-1:0]   cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a text byte
  localparam logic [1:0] ST_STEP = 2'd1;  // iterating on the held byte
  localparam logic [1:0] ST_FIN  = 2'd2;  // terminator: load result, clear state

  logic [1:0]                     state;
  logic [wgm_pkg::CHAR_W-1:0]     cur_char;
  wgm_pkg::match_state_t          mst;
  wgm_pkg::match_state_t          mst_next;
  logic                           consumed;
  logic                           slot_free;

  // configuration registers
  logic [wgm_pkg::PATTERN_W-1:0]  pattern_chars;
  logic [wgm_pkg::LEN_W-1:0]      pattern_length;
  logic                           case_fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= '0;
      case_fold      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wgm_pkg::REG_PATTERN_CHARS:  pattern_chars  <= cfg_data;
        wgm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wgm_pkg::LEN_W-1:0];
        wgm_pkg::REG_CASE_FOLD:      case_fold      <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // shared iteration unit
  wgm_step u_step (
    .pattern_chars  (pattern_chars),
    .pattern_length (pattern_length),
    .case_fold      (case_fold),
    .text_char      (cur_char),
    .cur            (mst),
    .nxt            (mst_next),
    .consumed       (consumed)
  );

  assign text_stall = (state != ST_IDLE);
  // result register can take a new value this cycle
  assign slot_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mst          <= wgm_pkg::STATE_CLEAR;
      result_valid <= 1'b0;
    end else begin
      // result register: loaded at the terminator, emptied when taken
      if (state == ST_FIN && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (text_valid) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          mst <= mst_next;
          if (consumed) begin
            // non-terminator bytes give no result
            state <= (cur_char == '0) ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            mst          <= wgm_pkg::STATE_CLEAR;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && text_valid) begin
      cur_char <= text_char;
    end
    if (state == ST_FIN && slot_free) begin
      matched <= mst.still_ok;
    end
  end

`ifndef SYNTH
  // a new result only comes out of the terminator state
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside terminator handling");

  // pattern position never exceeds MAX_PATTERN
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    mst.pattern_pos <= wgm_pkg::POS_W'(wgm_pkg::MAX_PATTERN))
    else $error("pattern position out of range");

  // a resume point always sits just after some star
  a_resume_pos: assert property (@(posedge clk) disable iff (rst)
    mst.resume_valid |-> (mst.resume_pos != '0))
    else $error("resume point at position zero");

  // emitting a result leaves the matcher cleared for the next string
  a_clear_after_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && slot_free) |=>
      (mst.still_ok && mst.pattern_pos == '0 && !mst.resume_valid && state == ST_IDLE))
    else $error("state not cleared after terminator");
`endif

endmodule

[rtl/wgm_step.sv]
// wgm_step: one iteration of the glob matching loop, shared across cycles
// fetches one pattern byte, compares it with the held text byte
// depends on wgm_pkg
module wgm_step (
  input  logic [wgm_pkg::PATTERN_W-1:0] pattern_chars,
  input  logic [wgm_pkg::LEN_W-1:0]     pattern_length,
  input  logic                          case_fold,
  input  logic [wgm_pkg::CHAR_W-1:0]    text_char,
  input  wgm_pkg::match_state_t         cur,
  output wgm_pkg::match_state_t         nxt,
  output logic                          consumed
);

  localparam logic [wgm_pkg::CHAR_W-1:0] GLOB_ONE = 8'h3F;
  localparam logic [wgm_pkg::CHAR_W-1:0] GLOB_ANY = 8'h2A;

  function automatic logic [wgm_pkg::CHAR_W-1:0] fold(
    input logic [wgm_pkg::CHAR_W-1:0] ch,
    input logic                       en
  );
    logic [wgm_pkg::CHAR_W-1:0] r;
    r = ch;
    if (en && ch >= 8'h41 && ch <= 8'h5A) begin
      r = ch + 8'h20;
    end
    return r;
  endfunction

  logic [wgm_pkg::LEN_W-1:0]  len_eff;
  logic [wgm_pkg::CHAR_W-1:0] pch;
  logic                       c_nz;
  logic                       eq;
  logic                       ret;
  logic [wgm_pkg::POS_W-1:0]  pos_inc;

  // clamp length, read the byte at the current position (zero past the end)
  always_comb begin
    if (pattern_length > wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN)) begin
      len_eff = wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
    if (cur.pattern_pos >= len_eff) begin
      pch = '0;
    end else begin
      pch = pattern_chars[cur.pattern_pos[2:0]*wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W];
    end
  end

  assign c_nz    = (text_char != '0);
  assign eq      = (fold(pch, case_fold) == fold(text_char, case_fold));
  assign pos_inc = cur.pattern_pos + wgm_pkg::POS_W'(1);

  always_comb begin
    nxt = cur;
    ret = 1'b0;
    if (!cur.still_ok || cur.decided_end) begin
      ret = 1'b1;
    end else if (cur.after_star) begin
      nxt.after_star = 1'b0;
      if (pch == '0 || pch == GLOB_ONE) begin
        nxt.decided_end = 1'b1;
      end
    end else if (pch == GLOB_ONE) begin
      if (c_nz) begin
        nxt.pattern_pos = pos_inc;
        ret = 1'b1;
      end else begin
        nxt.still_ok = 1'b0;
      end
    end else if (pch == GLOB_ANY) begin
      nxt.pattern_pos  = pos_inc;
      nxt.star_active  = 1'b1;
      nxt.resume_valid = 1'b1;
      nxt.resume_pos   = pos_inc;
      nxt.after_star   = 1'b1;
    end else if (pch == '0) begin
      if (cur.star_active) begin
        if (c_nz) begin
          ret = 1'b1;
        end else begin
          nxt.decided_end = 1'b1;
        end
      end else if (c_nz) begin
        if (cur.resume_valid) begin
          nxt.star_active = 1'b1;
          nxt.pattern_pos = cur.resume_pos;
        end else begin
          nxt.still_ok = 1'b0;
        end
      end else begin
        nxt.decided_end = 1'b1;
      end
    end else begin
      if (cur.star_active) begin
        if (eq) begin
          nxt.star_active = 1'b0;
        end else if (c_nz) begin
          ret = 1'b1;
        end else begin
          nxt.still_ok = 1'b0;
        end
      end else if (eq) begin
        nxt.pattern_pos = pos_inc;
        ret = 1'b1;
      end else if (cur.resume_valid) begin
        nxt.star_active = 1'b1;
        nxt.pattern_pos = cur.resume_pos;
      end else begin
        nxt.still_ok = 1'b0;
      end
    end
  end

  // the byte is done once the loop returns or the outcome is settled
  assign consumed = ret || !nxt.still_ok || nxt.decided_end;

endmodule

[dv/tb_glob_pkg.sv]
`timescale 1ns / 1ps
// tb_glob_pkg: scoreboard for the wildcard glob matcher bench
// keeps its own copy of the pattern registers and match state; needs wgm_pkg
package tb_glob_pkg;
  import wgm_pkg::*;

  localparam logic [CHAR_W-1:0] GLOB_ONE = 8'h3F;  // '?'
  localparam logic [CHAR_W-1:0] GLOB_ANY = 8'h2A;  // '*'

  class glob_scoreboard;
    logic [PATTERN_W-1:0] pat_bytes;
    logic [LEN_W-1:0]     pat_len;
    logic                 fold_en;

    int pos;
    int resume_pos;
    bit star_active;
    bit resume_valid;
    bit decided_end;
    bit still_ok;

    bit expected_matches[$];
    int mismatches;

    function new();
      pat_bytes  = '0;
      pat_len    = '0;
      fold_en    = 1'b0;
      mismatches = 0;
      clear_match();
    endfunction

    function void clear_match();
      pos          = 0;
      resume_pos   = 0;
      star_active  = 0;
      resume_valid = 0;
      decided_end  = 0;
      still_ok     = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] data);
      case (idx)
        REG_PATTERN_CHARS:  pat_bytes = data;
        REG_PATTERN_LENGTH: pat_len = data[LEN_W-1:0];
        REG_CASE_FOLD:      fold_en = data[0];
        default: ;
      endcase
    endfunction

    // bytes at or past the clamped length read as pattern end
    function logic [CHAR_W-1:0] pattern_byte(int at);
      int eff;
      eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      if (at >= eff)
        return '0;
      return pat_bytes[at*8 +: 8];
    endfunction

    function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] ch);
      if (fold_en && ch >= 8'h41 && ch <= 8'h5A)
        return ch + 8'h20;
      return ch;
    endfunction

    // step the pattern for one text byte until consumed or settled
    function void walk_pattern(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] p;
      logic [CHAR_W-1:0] nx;
      bit eq;
      while (still_ok && !decided_end) begin
        p = pattern_byte(pos);
        if (p == GLOB_ONE) begin
          if (c != 0) begin
            pos++;
            return;
          end
          still_ok = 0;
        end else if (p == GLOB_ANY) begin
          pos++;
          nx = pattern_byte(pos);
          if (nx == 0 || nx == GLOB_ONE)
            decided_end = 1;
          star_active  = 1;
          resume_valid = 1;
          resume_pos   = pos;
        end else if (p == 0) begin
          if (star_active) begin
            if (c != 0)
              return;
            decided_end = 1;
          end else if (c != 0) begin
            if (resume_valid) begin
              star_active = 1;
              pos = resume_pos;
            end else begin
              still_ok = 0;
            end
          end else begin
            decided_end = 1;
          end
        end else begin
          eq = (lower(p) == lower(c));
          if (star_active) begin
            if (eq)
              star_active = 0;
            else if (c != 0)
              return;
            else
              still_ok = 0;
          end else if (eq) begin
            pos++;
            return;
          end else if (resume_valid) begin
            star_active = 1;
            pos = resume_pos;
          end else begin
            still_ok = 0;
          end
        end
      end
    endfunction

    function void note_text_char(logic [CHAR_W-1:0] c);
      if (still_ok && !decided_end)
        walk_pattern(c);
      if (c == 0) begin
        expected_matches.push_back(still_ok);
        clear_match();
      end
    endfunction

    function void check_matched(logic m);
      bit want;
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: matched %0b with no string pending", m);
        return;
      end
      want = expected_matches.pop_front();
      if (m !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("matched mismatch: expected %0b got %0b", want, m);
      end
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_matches.size() == 0);
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for wildcard_glob_matcher
// streams text strings against many pattern settings; needs wgm_pkg and tb_glob_pkg
module tb_top;
  import wgm_pkg::*;
  import tb_glob_pkg::*;

  localparam int PHASES          = 8;
  localparam int CHARS_PER_PHASE = 110;
  localparam int SETTLE_CYCLES   = 2 * MAX_PATTERN + 8;  // worst byte walk plus margin
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                 clk;
  logic                 rst;
  logic                 text_valid;
  logic                 text_stall;
  logic [CHAR_W-1:0]    text_char;
  logic                 result_valid;
  logic                 result_stall;
  logic                 matched;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PATTERN_W-1:0] cfg_data;

  glob_scoreboard sb;

  // pattern as currently loaded, used to shape the text
  logic [PATTERN_W-1:0] cur_chars;
  logic [LEN_W-1:0]     cur_len;

  int tx_gap_max;
  int rx_gap_max;
  bit long_hold_req;
  int chars_sent;
  int idle_cycles;
  logic [CHAR_W-1:0] text_buf[$];

  wildcard_glob_matcher DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_char    (text_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: all sampling at the rising edge, before any drive of this edge lands
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (text_valid && !text_stall)
        sb.note_text_char(text_char);
      if (result_valid && !result_stall)
        sb.check_matched(matched);
      if ((text_valid && !text_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stall per result, one long hold-off on request
  initial begin : result_side
    int gap;
    result_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        // block the result path so the matcher backs up into the text side
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 0;
      end
      gap = $urandom_range(rx_gap_max);
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // one text request, with a random lead-in gap; valid stays up between requests unless a gap is drawn
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = $urandom_range(tx_gap_max);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_char  <= ch;
    do @(posedge clk); while (!(text_valid && !text_stall));
    chars_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
    send_char('0);
  endtask

  task automatic send_buffer();
    foreach (text_buf[i])
      send_char(text_buf[i]);
    send_char('0);
  endtask

  // quiet the text side, wait for every result, then let any byte walk finish
  task automatic drain();
    text_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [PATTERN_W-1:0] chars, input logic [LEN_W-1:0] len,
                              input logic fold);
    write_reg(REG_PATTERN_CHARS, chars);
    write_reg(REG_PATTERN_LENGTH, PATTERN_W'(len));
    write_reg(REG_CASE_FOLD, PATTERN_W'(fold));
    cfg_write <= 1'b0;
    cur_chars = chars;
    cur_len   = len;
  endtask

  // first pattern character lands in the lowest byte
  function automatic logic [PATTERN_W-1:0] pack_glob(input string s);
    logic [PATTERN_W-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < MAX_PATTERN; i++)
      r[i*8 +: 8] = s[i];
    return r;
  endfunction

  // mostly letters that patterns use, sometimes any nonzero byte
  function automatic logic [CHAR_W-1:0] rand_text_byte();
    case ($urandom_range(9))
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "B";
      4: return "c";
      5: return "C";
      6: return "z";
      default: return CHAR_W'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_pattern_byte();
    case ($urandom_range(9))
      0, 1: return GLOB_ANY;
      2, 3: return GLOB_ONE;
      4: return "a";
      5: return "b";
      6: return "C";
      7: return "c";
      8: return ($urandom_range(3) == 0) ? 8'h00 : 8'h41;  // sometimes an early end
      default: return CHAR_W'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic logic [PATTERN_W-1:0] rand_pattern();
    logic [PATTERN_W-1:0] r;
    for (int i = 0; i < MAX_PATTERN; i++)
      r[i*8 +: 8] = rand_pattern_byte();
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] ch);
    if (((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) && $urandom_range(1))
      return ch ^ 8'h20;
    return ch;
  endfunction

  // most strings follow the loaded pattern so the walk gets deep, the rest is noise
  function automatic void build_text();
    int eff;
    int n;
    logic [CHAR_W-1:0] p;
    text_buf.delete();
    if ($urandom_range(9) < 7) begin
      eff = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
      for (int k = 0; k < eff; k++) begin
        p = cur_chars[k*8 +: 8];
        if (p == 0)
          break;
        if (p == GLOB_ONE) begin
          text_buf.push_back(rand_text_byte());
        end else if (p == GLOB_ANY) begin
          n = $urandom_range(3);
          repeat (n) text_buf.push_back(rand_text_byte());
        end else begin
          text_buf.push_back(flip_case(p));
        end
      end
      // occasionally break the string
      if ($urandom_range(4) == 0) begin
        if (text_buf.size() > 0 && $urandom_range(1))
          text_buf[$urandom_range(text_buf.size() - 1)] = rand_text_byte();
        else
          text_buf.push_back(rand_text_byte());
      end
    end else begin
      n = $urandom_range(10);
      repeat (n) text_buf.push_back(rand_text_byte());
    end
  endfunction

  initial begin : main_seq
    int start;
    bit paused;
    sb = new();
    rst          = 1'b1;
    text_valid   = 1'b0;
    text_char    = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cur_chars    = '0;
    cur_len      = '0;
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    long_hold_req = 0;
    chars_sent   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset pattern is empty, so only the empty string matches
    send_str("");
    send_char(8'hFF);
    send_char('0);

    // star followed by '?' accepts at once, with case folding
    drain();
    load_pattern(pack_glob("a*?"), 4'd3, 1'b1);
    send_str("AZ");

    // length above the limit, zero byte inside the pattern ends it
    drain();
    load_pattern(pack_glob("h?l*o"), 4'd15, 1'b1);
    send_str("HeLLo");
    send_str("hxlyyoz");

    // early mismatch settles the outcome, rest of the string ignored
    drain();
    load_pattern(pack_glob("ab"), 4'd2, 1'b0);
    send_str("xbcd");
    send_str("AB");

    // random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: load_pattern(rand_pattern(), 4'd8, 1'b0);
        1: load_pattern(rand_pattern(), 4'd15, 1'b1);
        2: load_pattern('0, 4'd0, 1'b0);
        4: load_pattern({MAX_PATTERN{GLOB_ANY}}, 4'd8, 1'b1);
        6: load_pattern('1, 4'd8, 1'b1);
        default: load_pattern(rand_pattern(), LEN_W'($urandom_range(15)),
                              1'($urandom_range(1)));
      endcase
      case (ph)
        0: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        1: begin
          tx_gap_max = 18;
          rx_gap_max = 18;
        end
        3: begin
          // sender keeps pushing while the result side sits on its stall
          tx_gap_max = 0;
          rx_gap_max = 2;
          long_hold_req = 1;
        end
        default: begin
          tx_gap_max = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 4 : 18);
          rx_gap_max = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 4 : 18);
        end
      endcase
      start  = chars_sent;
      paused = 0;
      while (chars_sent - start < CHARS_PER_PHASE) begin
        build_text();
        send_buffer();
        // one mid-phase pause until every result is back
        if (ph == 5 && !paused && chars_sent - start > CHARS_PER_PHASE / 2) begin
          drain();
          paused = 1;
        end
      end
    end

    drain();
    if (sb.clean())
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
